// File: hdl/calendar_clock_tick_top_macros.svh
// ----------------------------------------------------------------------------
// calendar_clock_tick_top_macros.svh
// Assertion helpers for the calendar clock top level.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_CLOCK_TICK_TOP_MACROS_SVH
`define CALENDAR_CLOCK_TICK_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define CCT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define CCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/cct_pkg.sv
// ----------------------------------------------------------------------------
// cct_pkg
// Types, codes and calendar constants for the calendar clock.
// ----------------------------------------------------------------------------
`default_nettype none

package cct_pkg;

  // Request codes
  localparam logic [1:0] REQ_TICK     = 2'd0;
  localparam logic [1:0] REQ_SET_DATE = 2'd1;
  localparam logic [1:0] REQ_SET_TIME = 2'd2;

  localparam logic [13:0] MIN_YEAR   = 14'd2000;
  localparam logic [13:0] MAX_YEAR   = 14'd9999;
  localparam logic [13:0] RESET_YEAR = 14'd2000;

  localparam logic [5:0] SEC_MAX   = 6'd59;
  localparam logic [5:0] MIN_MAX   = 6'd59;
  localparam logic [4:0] HOUR_MAX  = 5'd23;
  localparam logic [3:0] MONTH_MAX = 4'd12;
  localparam logic [4:0] FEB_LEAP  = 5'd29;
  localparam logic [3:0] FEBRUARY  = 4'd2;

  // Divisibility by 25: y * inverse(25) mod 2^14 <= floor((2^14-1)/25)
  localparam logic [13:0] INV25       = 14'd7209;
  localparam logic [13:0] DIV25_LIMIT = 14'd655;

  // Month lengths by month number, unused codes read 31
  localparam logic [4:0] MONTH_LEN [16] = '{
    5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
  };

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cct_time_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  new_month;
    logic [4:0]  new_day;
    logic [13:0] new_year;
    logic [4:0]  new_hour;
    logic [5:0]  new_minute;
    logic [5:0]  new_second;
  } cct_req_t;

  // Gregorian rule: by 4, except by 100 unless by 400 (400 = 16 * 25)
  function automatic logic is_leap(input logic [13:0] y);
    logic [13:0] prod;
    logic        div25;
    prod  = y * INV25;
    div25 = (prod <= DIV25_LIMIT);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    if (m == FEBRUARY && leap) begin
      return FEB_LEAP;
    end
    return MONTH_LEN[m];
  endfunction

endpackage

`default_nettype wire

// File: hdl/cct_req_if.sv
// ----------------------------------------------------------------------------
// cct_req_if
// Request channel: tick or set command with its load values.
// ----------------------------------------------------------------------------
`default_nettype none

interface cct_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [3:0]  new_month;
  logic [4:0]  new_day;
  logic [13:0] new_year;
  logic [4:0]  new_hour;
  logic [5:0]  new_minute;
  logic [5:0]  new_second;

  modport source (
    output valid, req_type, new_month, new_day, new_year,
           new_hour, new_minute, new_second,
    input  ready
  );
  modport sink (
    input  valid, req_type, new_month, new_day, new_year,
           new_hour, new_minute, new_second,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/cct_res_if.sv
// ----------------------------------------------------------------------------
// cct_res_if
// Result channel: time and date after a request, plus reject flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface cct_res_if;
  logic        valid;
  logic        ready;
  logic [5:0]  cur_second;
  logic [5:0]  cur_minute;
  logic [4:0]  cur_hour;
  logic [4:0]  cur_day;
  logic [3:0]  cur_month;
  logic [13:0] cur_year;
  logic        rejected;

  modport source (
    output valid, cur_second, cur_minute, cur_hour, cur_day,
           cur_month, cur_year, rejected,
    input  ready
  );
  modport sink (
    input  valid, cur_second, cur_minute, cur_hour, cur_day,
           cur_month, cur_year, rejected,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/cct_update.sv
// ----------------------------------------------------------------------------
// cct_update
// Next time/date for one request: tick carry chain or checked set; other codes are rejected.
// ----------------------------------------------------------------------------
`default_nettype none

module cct_update (
  input  cct_pkg::cct_req_t  req,
  input  cct_pkg::cct_time_t cur,
  output cct_pkg::cct_time_t nxt,
  output logic               rejected
);

  logic       cur_leap;
  logic       new_leap;
  logic       date_ok;
  logic       time_ok;

  assign cur_leap = cct_pkg::is_leap(cur.year);
  assign new_leap = cct_pkg::is_leap(req.new_year);

  // Day is checked against the requested month and year
  assign date_ok = (req.new_month >= 4'd1) && (req.new_month <= cct_pkg::MONTH_MAX) &&
                   (req.new_year >= cct_pkg::MIN_YEAR) &&
                   (req.new_year <= cct_pkg::MAX_YEAR) &&
                   (req.new_day >= 5'd1) &&
                   (req.new_day <= cct_pkg::days_in(req.new_month, new_leap));

  assign time_ok = (req.new_hour <= cct_pkg::HOUR_MAX) &&
                   (req.new_minute <= cct_pkg::MIN_MAX) &&
                   (req.new_second <= cct_pkg::SEC_MAX);

  always_comb begin
    nxt      = cur;
    rejected = 1'b0;
    case (req.req_type)
      cct_pkg::REQ_TICK: begin
        if (cur.second < cct_pkg::SEC_MAX) begin
          nxt.second = cur.second + 6'd1;
        end else begin
          nxt.second = 6'd0;
          if (cur.minute < cct_pkg::MIN_MAX) begin
            nxt.minute = cur.minute + 6'd1;
          end else begin
            nxt.minute = 6'd0;
            if (cur.hour < cct_pkg::HOUR_MAX) begin
              nxt.hour = cur.hour + 5'd1;
            end else begin
              nxt.hour = 5'd0;
              if (cur.day < cct_pkg::days_in(cur.month, cur_leap)) begin
                nxt.day = cur.day + 5'd1;
              end else begin
                nxt.day = 5'd1;
                if (cur.month < cct_pkg::MONTH_MAX) begin
                  nxt.month = cur.month + 4'd1;
                end else begin
                  nxt.month = 4'd1;
                  if (cur.year >= cct_pkg::MAX_YEAR) begin
                    nxt.year = cct_pkg::MIN_YEAR;
                  end else begin
                    nxt.year = cur.year + 14'd1;
                  end
                end
              end
            end
          end
        end
      end
      cct_pkg::REQ_SET_DATE: begin
        if (date_ok) begin
          nxt.month = req.new_month;
          nxt.day   = req.new_day;
          nxt.year  = req.new_year;
        end else begin
          rejected = 1'b1;
        end
      end
      cct_pkg::REQ_SET_TIME: begin
        if (time_ok) begin
          nxt.hour   = req.new_hour;
          nxt.minute = req.new_minute;
          nxt.second = req.new_second;
        end else begin
          rejected = 1'b1;
        end
      end
      default: begin
        rejected = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/calendar_clock_tick_top.sv
// ----------------------------------------------------------------------------
// calendar_clock_tick_top
// Gregorian real-time clock and calendar driven by request transfers.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink): one transfer per tick or set command (valid/ready).
//   res (source): exactly one transfer per request, carrying the time and
//   date after that request and a rejected flag for a refused set or an
//   unused request code (state untouched in that case).
//   Path: input register, then result register. Throughput: one request
//   per cycle while res takes each result. The calendar state and the result
//   register are written in the same cycle from one pass through the carry /
//   check logic, so the next request already sees the new state.
//   Stall: while res is held off the result register keeps its transfer;
//   one more request may sit in the input register, then req.ready drops.
//   Reset (rst, synchronous): pipeline empties, clock reads 00:00:00 on
//   day 1, month 1, year 2000.
//   Leap years use a multiply-by-inverse divisibility test, no divider.
// ----------------------------------------------------------------------------
`default_nettype none
`include "calendar_clock_tick_top_macros.svh"

module calendar_clock_tick_top (
  input  wire logic clk,
  input  wire logic rst,
  cct_req_if.sink   req,
  cct_res_if.source res
);

  // Input register
  logic                s1_valid;
  cct_pkg::cct_req_t   s1_req;

  // Calendar state
  cct_pkg::cct_time_t  state;
  cct_pkg::cct_time_t  state_next;
  logic                rej_next;

  // Result register
  logic                out_valid;
  cct_pkg::cct_time_t  out_time;
  logic                out_rej;

  logic                adv;

  // Input stage moves on when the result register is free or draining
  assign adv       = s1_valid && (!out_valid || res.ready);
  assign req.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_req.req_type   <= req.req_type;
      s1_req.new_month  <= req.new_month;
      s1_req.new_day    <= req.new_day;
      s1_req.new_year   <= req.new_year;
      s1_req.new_hour   <= req.new_hour;
      s1_req.new_minute <= req.new_minute;
      s1_req.new_second <= req.new_second;
    end
  end

  cct_update u_update (
    .req      (s1_req),
    .cur      (state),
    .nxt      (state_next),
    .rejected (rej_next)
  );

  // State commits together with the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state.year   <= cct_pkg::RESET_YEAR;
      state.month  <= 4'd1;
      state.day    <= 5'd1;
      state.hour   <= 5'd0;
      state.minute <= 6'd0;
      state.second <= 6'd0;
    end else if (adv) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_time <= state_next;
      out_rej  <= rej_next;
    end
  end

  assign res.valid      = out_valid;
  assign res.cur_second = out_time.second;
  assign res.cur_minute = out_time.minute;
  assign res.cur_hour   = out_time.hour;
  assign res.cur_day    = out_time.day;
  assign res.cur_month  = out_time.month;
  assign res.cur_year   = out_time.year;
  assign res.rejected   = out_rej;

  // Checks
  `CCT_ASSERT_NOW(a_state_range, 1'b1,
    (state.second <= cct_pkg::SEC_MAX) && (state.minute <= cct_pkg::MIN_MAX) &&
    (state.hour <= cct_pkg::HOUR_MAX) && (state.month >= 4'd1) &&
    (state.month <= cct_pkg::MONTH_MAX) && (state.year >= cct_pkg::MIN_YEAR) &&
    (state.year <= cct_pkg::MAX_YEAR), "calendar state out of range")
  `CCT_ASSERT_NOW(a_day_range, 1'b1,
    (state.day >= 5'd1) &&
    (state.day <= cct_pkg::days_in(state.month, cct_pkg::is_leap(state.year))),
    "day beyond month length")
  `CCT_ASSERT_NEXT(a_hold_idle, !adv, $stable(state),
    "state changed without a request")
  `CCT_ASSERT_NEXT(a_hold_reject, adv && rej_next, $stable(state),
    "rejected request changed state")
  `CCT_ASSERT_NOW(a_ready_free, !out_valid, req.ready,
    "input stalled with empty result register")

endmodule

`default_nettype wire

// File: verif/cct_calendar_checker.sv
// ----------------------------------------------------------------------------
// cct_calendar_checker
// Watches the request and result channels of the calendar clock, keeps its
// own copy of the time and date, and compares each result transfer with the
// reading predicted for the oldest outstanding request.
// ----------------------------------------------------------------------------
`default_nettype none

module cct_calendar_checker (
  input  wire logic   clk,
  input  wire logic   rst,
  cct_req_if          req,
  cct_res_if          res,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        rejected;
  } clock_reading_t;

  cct_pkg::cct_time_t clock_now;
  clock_reading_t     readings_due[$];
  int unsigned        mismatches = 0;

  assign fail_count = mismatches;
  assign pending    = readings_due.size();

  function automatic bit leap_year(input logic [13:0] y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic [13:0] y);
    case (m)
      4'd2: begin
        return leap_year(y) ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        return 5'd30;
      end
      default: begin
        return 5'd31;
      end
    endcase
  endfunction

  // One second forward, carrying up through the year
  function automatic cct_pkg::cct_time_t tick_once(input cct_pkg::cct_time_t t);
    cct_pkg::cct_time_t n;
    n = t;
    n.second = 6'd0;
    if (t.second < cct_pkg::SEC_MAX) begin
      n.second = t.second + 6'd1;
      return n;
    end
    n.minute = 6'd0;
    if (t.minute < cct_pkg::MIN_MAX) begin
      n.minute = t.minute + 6'd1;
      return n;
    end
    n.hour = 5'd0;
    if (t.hour < cct_pkg::HOUR_MAX) begin
      n.hour = t.hour + 5'd1;
      return n;
    end
    n.day = 5'd1;
    if (t.day < month_days(t.month, t.year)) begin
      n.day = t.day + 5'd1;
      return n;
    end
    n.month = 4'd1;
    if (t.month < cct_pkg::MONTH_MAX) begin
      n.month = t.month + 4'd1;
      return n;
    end
    n.year = (t.year >= cct_pkg::MAX_YEAR) ? cct_pkg::MIN_YEAR : t.year + 14'd1;
    return n;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0d, actual %0d", name, want, seen);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    clock_reading_t want;
    logic           refused;
    if (rst) begin
      clock_now = '{year: cct_pkg::RESET_YEAR, month: 4'd1, day: 5'd1,
                    hour: 5'd0, minute: 6'd0, second: 6'd0};
      readings_due.delete();
    end else begin
      // Results first: each result is registered after its request, so a
      // request taken at this edge cannot be the one answered at this edge.
      if (res.valid && res.ready) begin
        if (readings_due.size() == 0) begin
          $error("result transfer with no request outstanding");
          mismatches++;
        end else begin
          want = readings_due.pop_front();
          check_field("cur_second", 32'(want.second),   32'(res.cur_second));
          check_field("cur_minute", 32'(want.minute),   32'(res.cur_minute));
          check_field("cur_hour",   32'(want.hour),     32'(res.cur_hour));
          check_field("cur_day",    32'(want.day),      32'(res.cur_day));
          check_field("cur_month",  32'(want.month),    32'(res.cur_month));
          check_field("cur_year",   32'(want.year),     32'(res.cur_year));
          check_field("rejected",   32'(want.rejected), 32'(res.rejected));
        end
      end
      if (req.valid && req.ready) begin
        refused = 1'b0;
        case (req.req_type)
          cct_pkg::REQ_TICK: begin
            clock_now = tick_once(clock_now);
          end
          cct_pkg::REQ_SET_DATE: begin
            // day is checked against the new month in the new year
            if (req.new_month >= 4'd1 && req.new_month <= cct_pkg::MONTH_MAX &&
                req.new_year >= cct_pkg::MIN_YEAR && req.new_year <= cct_pkg::MAX_YEAR &&
                req.new_day >= 5'd1 &&
                req.new_day <= month_days(req.new_month, req.new_year)) begin
              clock_now.month = req.new_month;
              clock_now.day   = req.new_day;
              clock_now.year  = req.new_year;
            end else begin
              refused = 1'b1;
            end
          end
          cct_pkg::REQ_SET_TIME: begin
            if (req.new_hour <= cct_pkg::HOUR_MAX && req.new_minute <= cct_pkg::MIN_MAX &&
                req.new_second <= cct_pkg::SEC_MAX) begin
              clock_now.hour   = req.new_hour;
              clock_now.minute = req.new_minute;
              clock_now.second = req.new_second;
            end else begin
              refused = 1'b1;
            end
          end
          default: begin
            refused = 1'b1;
          end
        endcase
        want = '{second: clock_now.second, minute: clock_now.minute,
                 hour: clock_now.hour, day: clock_now.day,
                 month: clock_now.month, year: clock_now.year,
                 rejected: refused};
        readings_due.push_back(want);
      end
    end
  end

endmodule

`default_nettype wire

// File: verif/calendar_clock_tick_top_tb.sv
// ----------------------------------------------------------------------------
// calendar_clock_tick_top_tb
// Drives tick, set-date and set-time requests into the calendar clock, with
// random idle bursts on the request side and random stalls on the result
// side. A checker beside the block predicts every result; this module only
// makes stimulus, watches the cycle budget and prints the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_clock_tick_top_tb;

  // Request code with no command behind it; the block must refuse it.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Worst case is roughly 1800 transfers; allow far more cycles.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst;
  int unsigned fails;
  int unsigned due;
  int unsigned idle_odds = 0;  // percent chance of an idle burst, both sides
  int unsigned hold_left = 0;
  int unsigned cycles = 0;

  cct_req_if req_ch ();
  cct_res_if res_ch ();

  calendar_clock_tick_top uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  cct_calendar_checker monitor (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .res        (res_ch),
    .fail_count (fails),
    .pending    (due)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side back-pressure: stall bursts of random length, drawn into
  // hold_left. With idle_odds at zero the sink takes every transfer.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_left    <= 0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else if (idle_odds != 0 && $urandom_range(1, 100) <= idle_odds) begin
      hold_left    <= $urandom_range(0, 16);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Hard stop if the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("calendar_clock_tick_top regression: fail");
      $finish;
    end
  end

  // Every field gets random content, so fields a request should ignore
  // still toggle through all their bits.
  function automatic cct_pkg::cct_req_t random_request();
    cct_pkg::cct_req_t r;
    r.req_type   = 2'($urandom);
    r.new_month  = 4'($urandom);
    r.new_day    = 5'($urandom);
    r.new_year   = 14'($urandom);
    r.new_hour   = 5'($urandom);
    r.new_minute = 6'($urandom);
    r.new_second = 6'($urandom);
    return r;
  endfunction

  function automatic cct_pkg::cct_req_t tick_req();
    cct_pkg::cct_req_t r;
    r = random_request();
    r.req_type = cct_pkg::REQ_TICK;
    return r;
  endfunction

  function automatic cct_pkg::cct_req_t date_req(input logic [13:0] y,
                                                 input logic [3:0] m,
                                                 input logic [4:0] d);
    cct_pkg::cct_req_t r;
    r = random_request();
    r.req_type  = cct_pkg::REQ_SET_DATE;
    r.new_year  = y;
    r.new_month = m;
    r.new_day   = d;
    return r;
  endfunction

  function automatic cct_pkg::cct_req_t time_req(input logic [4:0] h,
                                                 input logic [5:0] mi,
                                                 input logic [5:0] s);
    cct_pkg::cct_req_t r;
    r = random_request();
    r.req_type   = cct_pkg::REQ_SET_TIME;
    r.new_hour   = h;
    r.new_minute = mi;
    r.new_second = s;
    return r;
  endfunction

  // Years that matter to the leap rule and the wrap, plus a random one
  function automatic logic [13:0] pick_year();
    case ($urandom_range(0, 6))
      0: return cct_pkg::MIN_YEAR;
      1: return 14'd2100;
      2: return 14'd2400;
      3: return cct_pkg::MAX_YEAR;
      4: return 14'd2024;
      5: return 14'd2023;
      default: return 14'($urandom_range(cct_pkg::MIN_YEAR, cct_pkg::MAX_YEAR));
    endcase
  endfunction

  // Mostly ticks and in-range sets near the carry boundaries, with raw
  // (mostly out-of-range) sets and the unused code as noise.
  function automatic cct_pkg::cct_req_t mixed_request();
    cct_pkg::cct_req_t r;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      r = tick_req();
    end else if (pick < 60) begin
      if ($urandom_range(0, 1) == 0) begin
        r = time_req(5'd23, 6'd59, 6'($urandom_range(50, 59)));
      end else begin
        r = time_req(5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                     6'($urandom_range(0, 59)));
      end
    end else if (pick < 75) begin
      r = date_req(pick_year(), 4'($urandom_range(1, 12)), 5'($urandom_range(27, 31)));
    end else if (pick < 85) begin
      r = random_request();
      r.req_type = cct_pkg::REQ_SET_DATE;
    end else if (pick < 95) begin
      r = random_request();
      r.req_type = cct_pkg::REQ_SET_TIME;
    end else begin
      r = random_request();
      r.req_type = REQ_UNUSED;
    end
    return r;
  endfunction

  // One request transfer. An optional idle burst comes first; valid then
  // stays up until the edge at which ready is seen high.
  task automatic push_request(input cct_pkg::cct_req_t r);
    int unsigned gap;
    if (idle_odds != 0 && $urandom_range(1, 100) <= idle_odds) begin
      gap = $urandom_range(1, 17);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= r.req_type;
    req_ch.new_month  <= r.new_month;
    req_ch.new_day    <= r.new_day;
    req_ch.new_year   <= r.new_year;
    req_ch.new_hour   <= r.new_hour;
    req_ch.new_minute <= r.new_minute;
    req_ch.new_second <= r.new_second;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // A random phase. About one step in ten is a full rollover run: a date
  // near month end, a time just before midnight, then ticks across it.
  task automatic run_phase(input int unsigned n_items, input int unsigned odds);
    int unsigned sent;
    idle_odds = odds;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        push_request(date_req(pick_year(), 4'($urandom_range(1, 12)),
                              5'($urandom_range(28, 31))));
        push_request(time_req(5'd23, 6'd59, 6'd58));
        repeat (3) push_request(tick_req());
        sent += 5;
      end else begin
        push_request(mixed_request());
        sent++;
      end
    end
  endtask

  initial begin
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= cct_pkg::REQ_TICK;
    req_ch.new_month  <= 4'd0;
    req_ch.new_day    <= 5'd0;
    req_ch.new_year   <= 14'd0;
    req_ch.new_hour   <= 5'd0;
    req_ch.new_minute <= 6'd0;
    req_ch.new_second <= 6'd0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part -----------------------------------------------------
    idle_odds = 10;
    push_request(tick_req());                         // first second after reset
    push_request('1);                                 // unused code, fields all ones
    // last second of the last year wraps to the first year
    push_request(date_req(cct_pkg::MAX_YEAR, 4'd12, 5'd31));
    push_request(time_req(5'd23, 6'd59, 6'd59));
    push_request(tick_req());
    // midnight into Feb 29 of a leap year
    push_request(date_req(14'd2024, 4'd2, 5'd28));
    push_request(time_req(5'd23, 6'd59, 6'd59));
    push_request(tick_req());
    // Feb 29 checked against the new year: century vs. 400-year rule
    push_request(date_req(14'd2100, 4'd2, 5'd29));    // refused
    push_request(date_req(14'd2000, 4'd2, 5'd29));    // taken
    push_request(date_req(14'd2023, 4'd2, 5'd29));    // refused
    push_request(date_req(14'd2023, 4'd4, 5'd31));    // April has 30 days
    // out-of-range date fields, each refused whole
    push_request(date_req(14'd2023, 4'd0, 5'd1));
    push_request(date_req(14'd2023, 4'd13, 5'd1));
    push_request(date_req(14'd2023, 4'd6, 5'd0));
    push_request(date_req(14'd1999, 4'd6, 5'd1));
    push_request(date_req(14'd10000, 4'd6, 5'd1));
    push_request(date_req(14'h3fff, 4'hf, 5'd31));
    // out-of-range time fields, then one in-range time
    push_request(time_req(5'd24, 6'd0, 6'd0));
    push_request(time_req(5'd0, 6'd60, 6'd0));
    push_request(time_req(5'd0, 6'd0, 6'd63));
    push_request(time_req(5'd31, 6'd63, 6'd63));
    push_request(time_req(5'd0, 6'd0, 6'd0));
    // Feb 29 2000 still stands; midnight carries into March
    push_request(time_req(5'd23, 6'd59, 6'd59));
    push_request(tick_req());

    // ---- random part: light, none, heavy idling, then a calm finish --------
    run_phase(450, 10);
    run_phase(450, 0);
    run_phase(450, 35);
    run_phase(400, 0);
    req_ch.valid <= 1'b0;

    // let the checker log the last request, then drain
    @(posedge clk);
    wait (due == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && due == 0) begin
      $display("calendar_clock_tick_top regression: pass");
    end else begin
      $display("calendar_clock_tick_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
